@@ sv/hdpid_pkg.sv @@
// ----------------------------------------------------------------------------
// hdpid_pkg
// Shared widths, constants and register indexes of the heading PID core.
// ----------------------------------------------------------------------------
package hdpid_pkg;

  localparam int unsigned HEAD_W   = 9;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned TOL_W    = 8;
  localparam int unsigned ERR_W    = 9;
  localparam int unsigned MAG_W    = 8;
  localparam int unsigned PWR_W    = 8;
  localparam int unsigned DIV_W    = 44;
  localparam int unsigned MUL_A_W  = 32;
  localparam int unsigned MUL_B_W  = 20;
  localparam int unsigned PROD_W   = MUL_A_W + MUL_B_W;
  localparam int unsigned ACC_W    = 51;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // error times elapsed time, and its divide by one second
  localparam int unsigned INC_W       = 40;
  localparam int unsigned RECIP_LSB   = INC_W - MUL_A_W;
  localparam int unsigned RECIP_SHIFT = 31;

  localparam logic [HEAD_W-1:0]  FULL_CIRCLE = 9'd360;
  localparam logic [HEAD_W:0]    HALF_CIRCLE = 10'd180;
  localparam logic [MUL_B_W-1:0] US_PER_S    = 20'd1000000;
  // floor(2^31 * 256 / 1e6)
  localparam logic [MUL_B_W-1:0] RECIP_US    = 20'd549755;
  localparam logic [PWR_W-1:0]   POWER_MAX   = 8'd255;
  localparam logic [PWR_W-1:0]   POWER_MIN   = 8'd220;
  localparam logic [ACC_W-1:0]   CUT_LIMIT_Q8 = 51'd8960;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 3'd5;

endpackage

@@ sv/hdpid_div.sv @@
// ----------------------------------------------------------------------------
// hdpid_div
// Restoring divider, one quotient bit per cycle; done pulses with the result.
// ----------------------------------------------------------------------------
module hdpid_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [hdpid_pkg::DIV_W-1:0]   dividend_i,
  input  logic [hdpid_pkg::TIME_W-1:0]  divisor_i,
  output logic                          done_o,
  output logic [hdpid_pkg::DIV_W-1:0]   quotient_o
);

  localparam int unsigned CNT_W = $clog2(hdpid_pkg::DIV_W);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic [hdpid_pkg::TIME_W-1:0]  rem_q, rem_d;
  logic [hdpid_pkg::TIME_W-1:0]  div_q, div_d;
  logic [hdpid_pkg::DIV_W-1:0]   quo_q, quo_d;
  logic [hdpid_pkg::TIME_W:0]    trial;
  logic [hdpid_pkg::TIME_W:0]    diff;
  logic                          fits;

  assign trial = {rem_q, quo_q[hdpid_pkg::DIV_W-1]};
  assign diff  = trial - {1'b0, div_q};
  assign fits  = trial >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    div_d  = div_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(hdpid_pkg::DIV_W - 1);
      rem_d  = '0;
      div_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[hdpid_pkg::TIME_W-1:0] : trial[hdpid_pkg::TIME_W-1:0];
      quo_d = {quo_q[hdpid_pkg::DIV_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ sv/heading_pid_differential_drive_core.sv @@
// ----------------------------------------------------------------------------
// heading_pid_differential_drive_core
// Heading PID step for a two wheel drive: wraps the heading error, runs
// P, I and D terms on one shared multiplier plus a divider for the D term, maps to wheel power.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  s_axis   | in        | tdata: heading[8:0], time_us[40:9]; tuser: restart
//  m_axis   | out       | tdata: left_power, right_power, left_forward,
//           |           |        right_forward, signed_error, target_reached
//  cfg      | in        | cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
// The restoring divide of the D term by the elapsed time dominates each
// transaction and is skipped when the elapsed time is zero; the integral
// divides by one second with a reciprocal multiply and up to three correction
// steps. s_axis_tready is high only while the sequencer is idle.
// A finished result waits in the output register; the next transaction is
// taken while it waits. Reset sets default configuration, clears PID state.
// ----------------------------------------------------------------------------
module heading_pid_differential_drive_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // heading[8:0], time_us[40:9], zero pad
  input  logic        s_axis_tuser,   // restart
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // left_power[7:0], right_power[15:8],
                                      // left_forward[16], right_forward[17],
                                      // signed_error[26:18], target_reached[27]
  input  logic                              cfg_we_i,
  input  logic [hdpid_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [hdpid_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  typedef enum logic [14:0] {
    ST_IDLE = 15'b000000000000001,
    ST_PREP = 15'b000000000000010,
    ST_MINC = 15'b000000000000100,
    ST_SINC = 15'b000000000001000,
    ST_QINC = 15'b000000000010000,
    ST_RINC = 15'b000000000100000,
    ST_DINC = 15'b000000001000000,
    ST_MD1  = 15'b000000010000000,
    ST_MD2  = 15'b000000100000000,
    ST_SDD  = 15'b000001000000000,
    ST_DD   = 15'b000010000000000,
    ST_MI   = 15'b000100000000000,
    ST_MP   = 15'b001000000000000,
    ST_ADDP = 15'b010000000000000,
    ST_OUT  = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [hdpid_pkg::HEAD_W-1:0] target_q;
  logic                         mode_q;
  logic [hdpid_pkg::GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic [hdpid_pkg::TOL_W-1:0]  tol_q;

  // PID state
  logic [hdpid_pkg::TIME_W-1:0] last_time_q, last_time_d;
  logic [hdpid_pkg::MAG_W-1:0]  last_err_q, last_err_d;
  logic [hdpid_pkg::TIME_W-1:0] integ_q, integ_d;

  // per transaction
  logic [hdpid_pkg::HEAD_W-1:0] head_q, head_d;
  logic [hdpid_pkg::TIME_W-1:0] now_q, now_d;
  logic                         restart_q, restart_d;
  logic [hdpid_pkg::TIME_W-1:0] dt_q, dt_d;
  logic [hdpid_pkg::ERR_W-1:0]  serr_q, serr_d;
  logic [hdpid_pkg::MAG_W-1:0]  e_q, e_d;
  logic [hdpid_pkg::MAG_W-1:0]  dmag_q, dmag_d;
  logic                         dneg_q, dneg_d;
  logic [hdpid_pkg::INC_W-1:0]  num_q, num_d;
  logic [hdpid_pkg::TIME_W-1:0] qinc_q, qinc_d;
  logic [hdpid_pkg::PROD_W-1:0] prod_q;
  logic signed [hdpid_pkg::ACC_W-1:0] acc_q, acc_d;

  // output register
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_data_q, out_data_d;

  // shared units
  logic [hdpid_pkg::MUL_A_W-1:0] mul_a;
  logic [hdpid_pkg::MUL_B_W-1:0] mul_b;
  logic                          mul_en;
  logic                          div_start;
  logic [hdpid_pkg::DIV_W-1:0]   div_dividend;
  logic [hdpid_pkg::TIME_W-1:0]  div_divisor;
  logic                          div_done;
  logic [hdpid_pkg::DIV_W-1:0]   div_quot;

  // error wrap
  logic [hdpid_pkg::HEAD_W-1:0]     head_n, tgt_n;
  logic signed [hdpid_pkg::HEAD_W:0] raw_diff, wrap_diff;
  logic [hdpid_pkg::TIME_W-1:0]     eff_last_time, eff_integ;
  logic [hdpid_pkg::MAG_W-1:0]      eff_last_err, e_now;
  logic [hdpid_pkg::TIME_W:0]       integ_sum;
  logic signed [hdpid_pkg::ACC_W-1:0] dq_signed, prod_signed;

  // output mapping
  logic [hdpid_pkg::ACC_W-1:0] s_mag;
  logic [14:0]                 cut_round;
  logic [hdpid_pkg::PWR_W-1:0] cut, turn_pwr, lp, rp;
  logic                        lf, rf, reached;

  hdpid_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      mode_q   <= 1'b0;
      gain_p_q <= 16'd256;
      gain_i_q <= '0;
      gain_d_q <= '0;
      tol_q    <= 8'd5;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hdpid_pkg::REG_TARGET:    target_q <= cfg_data_i[hdpid_pkg::HEAD_W-1:0];
        hdpid_pkg::REG_MODE:      mode_q   <= cfg_data_i[0];
        hdpid_pkg::REG_GAIN_P:    gain_p_q <= cfg_data_i;
        hdpid_pkg::REG_GAIN_I:    gain_i_q <= cfg_data_i;
        hdpid_pkg::REG_GAIN_D:    gain_d_q <= cfg_data_i;
        hdpid_pkg::REG_TOLERANCE: tol_q    <= cfg_data_i[hdpid_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // heading error, state clear on restart
  always_comb begin
    head_n = (head_q >= hdpid_pkg::FULL_CIRCLE) ? head_q - hdpid_pkg::FULL_CIRCLE : head_q;
    tgt_n  = (target_q >= hdpid_pkg::FULL_CIRCLE) ? target_q - hdpid_pkg::FULL_CIRCLE
                                                  : target_q;
    raw_diff = $signed({1'b0, head_n}) - $signed({1'b0, tgt_n});
    if (raw_diff > $signed(hdpid_pkg::HALF_CIRCLE)) begin
      wrap_diff = raw_diff - $signed({1'b0, hdpid_pkg::FULL_CIRCLE});
    end else if (raw_diff < -$signed(hdpid_pkg::HALF_CIRCLE)) begin
      wrap_diff = raw_diff + $signed({1'b0, hdpid_pkg::FULL_CIRCLE});
    end else begin
      wrap_diff = raw_diff;
    end
    e_now = wrap_diff[hdpid_pkg::HEAD_W] ? hdpid_pkg::MAG_W'(-wrap_diff)
                                         : hdpid_pkg::MAG_W'(wrap_diff);
    eff_last_time = restart_q ? '0 : last_time_q;
    eff_last_err  = restart_q ? '0 : last_err_q;
    eff_integ     = restart_q ? '0 : integ_q;
  end

  assign integ_sum   = {1'b0, integ_q} + {1'b0, qinc_q};
  assign dq_signed   = dneg_q ? -$signed({{(hdpid_pkg::ACC_W-hdpid_pkg::DIV_W){1'b0}}, div_quot})
                              :  $signed({{(hdpid_pkg::ACC_W-hdpid_pkg::DIV_W){1'b0}}, div_quot});
  assign prod_signed = $signed({1'b0, prod_q[hdpid_pkg::ACC_W-2:0]});

  // multiplier operand selection
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_q)
      ST_MINC: begin
        mul_a = dt_q;
        mul_b = hdpid_pkg::MUL_B_W'(e_q);
      end
      ST_SINC: begin
        mul_a = prod_q[hdpid_pkg::INC_W-1:hdpid_pkg::RECIP_LSB];
        mul_b = hdpid_pkg::RECIP_US;
      end
      ST_QINC: begin
        mul_a = hdpid_pkg::MUL_A_W'(prod_q[hdpid_pkg::PROD_W-1:hdpid_pkg::RECIP_SHIFT]);
        mul_b = hdpid_pkg::US_PER_S;
      end
      ST_MD1: begin
        mul_a = hdpid_pkg::MUL_A_W'(gain_d_q);
        mul_b = hdpid_pkg::MUL_B_W'(dmag_q);
      end
      ST_MD2: begin
        mul_a = prod_q[hdpid_pkg::MUL_A_W-1:0];
        mul_b = hdpid_pkg::US_PER_S;
      end
      ST_MI: begin
        mul_a = integ_q;
        mul_b = hdpid_pkg::MUL_B_W'(gain_i_q);
      end
      ST_MP: begin
        mul_a = hdpid_pkg::MUL_A_W'(gain_p_q);
        mul_b = hdpid_pkg::MUL_B_W'(e_q);
      end
      default: mul_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q <= mul_a * mul_b;
    end
  end

  // output mapping
  always_comb begin
    s_mag     = acc_q[hdpid_pkg::ACC_W-1] ? hdpid_pkg::ACC_W'(-acc_q)
                                          : hdpid_pkg::ACC_W'(acc_q);
    cut_round = s_mag[14:0] + 15'd255;
    cut       = (s_mag > hdpid_pkg::CUT_LIMIT_Q8) ? hdpid_pkg::POWER_MAX
                                                  : hdpid_pkg::PWR_W'(cut_round[14:8]);
    if (|s_mag[hdpid_pkg::ACC_W-1:16]) begin
      turn_pwr = hdpid_pkg::POWER_MAX;
    end else if (s_mag[15:8] < hdpid_pkg::POWER_MIN) begin
      turn_pwr = hdpid_pkg::POWER_MIN;
    end else begin
      turn_pwr = s_mag[15:8];
    end
    if (!mode_q) begin
      lf = 1'b1;
      rf = 1'b1;
      lp = serr_q[hdpid_pkg::ERR_W-1] ? hdpid_pkg::POWER_MAX : hdpid_pkg::POWER_MAX - cut;
      rp = serr_q[hdpid_pkg::ERR_W-1] ? hdpid_pkg::POWER_MAX - cut : hdpid_pkg::POWER_MAX;
    end else begin
      lp = turn_pwr;
      rp = turn_pwr;
      lf = !(!serr_q[hdpid_pkg::ERR_W-1] && (serr_q != '0));
      rf = !lf;
    end
    reached = e_q <= tol_q;
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    now_d        = now_q;
    restart_d    = restart_q;
    dt_d         = dt_q;
    serr_d       = serr_q;
    e_d          = e_q;
    dmag_d       = dmag_q;
    dneg_d       = dneg_q;
    num_d        = num_q;
    qinc_d       = qinc_q;
    acc_d        = acc_q;
    last_time_d  = last_time_q;
    last_err_d   = last_err_q;
    integ_d      = integ_q;
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    div_start    = 1'b0;
    div_dividend = prod_q[hdpid_pkg::DIV_W-1:0];
    div_divisor  = dt_q;
    s_axis_tready = 1'b0;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          head_d    = s_axis_tdata[8:0];
          now_d     = s_axis_tdata[40:9];
          restart_d = s_axis_tuser;
          state_d   = ST_PREP;
        end
      end
      ST_PREP: begin
        serr_d      = wrap_diff[hdpid_pkg::ERR_W-1:0];
        e_d         = e_now;
        dt_d        = now_q - eff_last_time;
        dneg_d      = e_now < eff_last_err;
        dmag_d      = (e_now < eff_last_err) ? eff_last_err - e_now : e_now - eff_last_err;
        integ_d     = eff_integ;
        last_time_d = now_q;
        last_err_d  = e_now;
        state_d     = ST_MINC;
      end
      ST_MINC: state_d = ST_SINC;
      // estimate falls short of the quotient by at most three
      ST_SINC: begin
        num_d   = prod_q[hdpid_pkg::INC_W-1:0];
        state_d = ST_QINC;
      end
      ST_QINC: begin
        qinc_d  = hdpid_pkg::TIME_W'(prod_q[hdpid_pkg::PROD_W-1:hdpid_pkg::RECIP_SHIFT]);
        state_d = ST_RINC;
      end
      ST_RINC: begin
        num_d   = num_q - prod_q[hdpid_pkg::INC_W-1:0];
        state_d = ST_DINC;
      end
      ST_DINC: begin
        if (num_q >= hdpid_pkg::INC_W'(hdpid_pkg::US_PER_S)) begin
          num_d  = num_q - hdpid_pkg::INC_W'(hdpid_pkg::US_PER_S);
          qinc_d = qinc_q + 1'b1;
        end else begin
          integ_d = integ_sum[hdpid_pkg::TIME_W] ? '1 : integ_sum[hdpid_pkg::TIME_W-1:0];
          state_d = ST_MD1;
        end
      end
      ST_MD1: state_d = ST_MD2;
      ST_MD2: state_d = ST_SDD;
      ST_SDD: begin
        if (dt_q == '0) begin
          acc_d = dneg_q ? -$signed({1'b0, prod_q[hdpid_pkg::ACC_W-2:0]}) : prod_signed;
          state_d = ST_MI;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DD;
        end
      end
      ST_DD: begin
        if (div_done) begin
          acc_d   = dq_signed;
          state_d = ST_MI;
        end
      end
      ST_MI: state_d = ST_MP;
      ST_MP: begin
        acc_d   = acc_q + prod_signed;
        state_d = ST_ADDP;
      end
      ST_ADDP: begin
        acc_d   = acc_q + prod_signed;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {4'b0, reached, serr_q, rf, lf, rp, lp};
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      last_time_q <= '0;
      last_err_q  <= '0;
      integ_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      last_time_q <= last_time_d;
      last_err_q  <= last_err_d;
      integ_q     <= integ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q     <= head_d;
    now_q      <= now_d;
    restart_q  <= restart_d;
    dt_q       <= dt_d;
    serr_q     <= serr_d;
    e_q        <= e_d;
    dmag_q     <= dmag_d;
    dneg_q     <= dneg_d;
    num_q      <= num_d;
    qinc_q     <= qinc_d;
    acc_q      <= acc_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the heading PID core. A driver streams compass fixes
// in random bursts, a monitor predicts wheel commands per transaction and
// compares them field by field against the output stream under random stalls.
// ----------------------------------------------------------------------------
module testbench;

  localparam int DEG_FULL   = hdpid_pkg::FULL_CIRCLE;
  localparam int DEG_HALF   = hdpid_pkg::HALF_CIRCLE;
  localparam int PWR_TOP    = hdpid_pkg::POWER_MAX;
  localparam int PWR_FLOOR  = hdpid_pkg::POWER_MIN;
  localparam longint USEC   = hdpid_pkg::US_PER_S;
  localparam longint unsigned CUT_LIMIT = hdpid_pkg::CUT_LIMIT_Q8;
  localparam logic [hdpid_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd6;
  localparam int IDLE_LIMIT = 4000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_FIXES = 112;

  typedef struct packed {
    logic        restart;
    logic [31:0] stamp;
    logic [8:0]  heading;
  } fix_t;

  typedef struct packed {
    logic              reached;
    logic signed [8:0] err;
    logic              right_fwd;
    logic              left_fwd;
    logic [7:0]        right_pwr;
    logic [7:0]        left_pwr;
  } drive_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [47:0]                      s_axis_tdata = '0;
  logic                             s_axis_tuser = 1'b0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [31:0]                      m_axis_tdata;
  logic                             cfg_we_i = 1'b0;
  logic [hdpid_pkg::CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [hdpid_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  // controller copy: registers and loop state
  logic [8:0]  tgt_deg = 9'd0;
  logic        turn_mode = 1'b0;
  logic [15:0] kp = 16'd256;
  logic [15:0] ki = 16'd0;
  logic [15:0] kd = 16'd0;
  logic [7:0]  tol_deg = 8'd5;
  logic [31:0] prev_stamp = '0;
  logic [7:0]  prev_err = '0;
  logic [31:0] err_integral = '0;

  fix_t   pending_fixes[$];
  drive_t drive_due[$];
  logic   in_taken = 1'b0;
  int     fail_cnt = 0;
  int     idle_cycles = 0;
  int     gap_left = 0;
  int     burst_left = 0;
  int     stall_seg = 0;
  rx_mode_e stall_mode = RX_OPEN;
  logic [31:0] stamp_us = '0;

  heading_pid_differential_drive_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic drive_t steer_step(fix_t fx);
    int head, tgt, serr, e, cut;
    logic [31:0] dt;
    longint dterm, sum;
    longint unsigned e64, inc, acc, s, pw;
    drive_t r;
    if (fx.restart) begin
      prev_stamp = '0;
      prev_err = '0;
      err_integral = '0;
    end
    head = fx.heading;
    tgt = tgt_deg;
    if (head >= DEG_FULL) head -= DEG_FULL;
    if (tgt >= DEG_FULL) tgt -= DEG_FULL;
    serr = head - tgt;
    if (serr > DEG_HALF) serr -= DEG_FULL;
    else if (serr < -DEG_HALF) serr += DEG_FULL;
    e = (serr < 0) ? -serr : serr;
    dt = fx.stamp - prev_stamp;
    prev_stamp = fx.stamp;
    dterm = longint'(kd) * longint'(e - int'(prev_err)) * USEC;
    if (dt != 0) dterm = dterm / longint'(dt);
    e64 = longint'(e);
    inc = (e64 * longint'(dt)) / longint'(USEC);
    acc = longint'(err_integral) + inc;
    if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
    err_integral = acc[31:0];
    prev_err = e[7:0];
    sum = longint'(kp) * longint'(e) + dterm + longint'(ki) * longint'(err_integral);
    s = (sum < 0) ? -sum : sum;
    if (!turn_mode) begin
      // fractional power rounds the slowed wheel down
      cut = (s > CUT_LIMIT) ? PWR_TOP : int'((s + 64'd255) >> 8);
      r.left_pwr = 8'(PWR_TOP);
      r.right_pwr = 8'(PWR_TOP);
      if (serr < 0) r.right_pwr = 8'(PWR_TOP - cut);
      else r.left_pwr = 8'(PWR_TOP - cut);
      r.left_fwd = 1'b1;
      r.right_fwd = 1'b1;
    end else begin
      pw = s >> 8;
      if (pw > PWR_TOP) pw = PWR_TOP;
      else if (pw < PWR_FLOOR) pw = PWR_FLOOR;
      r.left_pwr = pw[7:0];
      r.right_pwr = pw[7:0];
      r.left_fwd = (serr <= 0);
      r.right_fwd = (serr > 0);
    end
    r.err = serr[8:0];
    r.reached = (e <= int'(tol_deg));
    return r;
  endfunction

  task automatic check_drive(drive_t got);
    drive_t want;
    if (drive_due.size() == 0) begin
      fail_cnt++;
      if (fail_cnt <= 10) $display("unexpected transaction: tdata=%h", got);
    end else begin
      want = drive_due.pop_front();
      if (got.left_pwr != want.left_pwr || got.right_pwr != want.right_pwr ||
          got.left_fwd != want.left_fwd || got.right_fwd != want.right_fwd ||
          got.err != want.err || got.reached != want.reached) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display({"mismatch: exp lp=%0d rp=%0d lf=%0b rf=%0b err=%0d hit=%0b",
                    " | got lp=%0d rp=%0d lf=%0b rf=%0b err=%0d hit=%0b"},
                   want.left_pwr, want.right_pwr, want.left_fwd, want.right_fwd,
                   $signed(want.err), want.reached, got.left_pwr, got.right_pwr,
                   got.left_fwd, got.right_fwd, $signed(got.err), got.reached);
      end
    end
  endtask

  // monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken = s_axis_tvalid && s_axis_tready;
      if (in_taken) begin
        drive_due.push_back(steer_step(fix_t'({s_axis_tuser, s_axis_tdata[40:0]})));
        void'(pending_fixes.pop_front());
      end
      if (m_axis_tvalid && m_axis_tready) check_drive(drive_t'(m_axis_tdata[27:0]));
      if (in_taken || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // driver: bursts of transactions with random gaps
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && !in_taken) begin
      end else if (gap_left != 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_fixes.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, pending_fixes[0].stamp, pending_fixes[0].heading};
        s_axis_tuser <= pending_fixes[0].restart;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 15);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 150);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk_i) begin
    if (stall_seg == 0) begin
      stall_mode = rx_mode_e'($urandom_range(0, 3));
      stall_seg = $urandom_range(50, 600);
    end else begin
      stall_seg--;
    end
    case (stall_mode)
      RX_OPEN:   m_axis_tready <= 1'b1;
      RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: m_axis_tready <= ($urandom_range(0, 7) == 0);
      default:   m_axis_tready <= stall_seg[3];
    endcase
  end

  task automatic add_fix(int h, logic [31:0] t, logic r);
    pending_fixes.push_back('{restart: r, stamp: t, heading: 9'(h)});
  endtask

  task automatic write_reg(logic [hdpid_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      hdpid_pkg::REG_TARGET:    tgt_deg = val[8:0];
      hdpid_pkg::REG_MODE:      turn_mode = val[0];
      hdpid_pkg::REG_GAIN_P:    kp = val;
      hdpid_pkg::REG_GAIN_I:    ki = val;
      hdpid_pkg::REG_GAIN_D:    kd = val;
      hdpid_pkg::REG_TOLERANCE: tol_deg = val[7:0];
      default: ;
    endcase
  endtask

  task automatic load_setup(logic [15:0] tgt, logic [15:0] mode, logic [15:0] gp,
                            logic [15:0] gi, logic [15:0] gd, logic [15:0] tol);
    write_reg(hdpid_pkg::REG_TARGET, tgt);
    write_reg(hdpid_pkg::REG_MODE, mode);
    write_reg(hdpid_pkg::REG_GAIN_P, gp);
    write_reg(hdpid_pkg::REG_GAIN_I, gi);
    write_reg(hdpid_pkg::REG_GAIN_D, gd);
    write_reg(hdpid_pkg::REG_TOLERANCE, tol);
    if ($urandom_range(0, 1) == 1)
      write_reg(REG_SPARE | 3'($urandom_range(0, 1)), 16'($urandom));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_fixes.size() != 0 || s_axis_tvalid || drive_due.size() != 0)
      @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_gain(int low_max);
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(0, low_max));
      1:       return ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(0, 1023));
    endcase
  endfunction

  task automatic load_random_setup();
    logic [15:0] tgt, mode, tol;
    tgt = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(360, 511))
                                      : 16'($urandom_range(0, 359));
    mode = 16'($urandom_range(0, 1));
    if ($urandom_range(0, 3) == 0) begin
      tgt[15:9] = 7'($urandom);
      mode[15:1] = 15'($urandom);
    end
    tol = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 255))
                                      : 16'($urandom_range(0, 20));
    load_setup(tgt, mode, pick_gain(512), pick_gain(16), pick_gain(64), tol);
  endtask

  task automatic queue_random_run(int count);
    int tgt, h;
    tgt = (tgt_deg >= 9'(DEG_FULL)) ? int'(tgt_deg) - DEG_FULL : int'(tgt_deg);
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(0, 15))
        0:       stamp_us = stamp_us;
        1:       stamp_us = stamp_us + 32'($urandom_range(1, 1000));
        2:       stamp_us = stamp_us + 32'($urandom);
        3:       stamp_us = 32'($urandom);
        default: stamp_us = stamp_us + 32'($urandom_range(700000, 800000));
      endcase
      case ($urandom_range(0, 15))
        10, 11, 12, 13: h = $urandom_range(0, 359);
        14, 15:         h = $urandom_range(360, 511);
        default:        h = (tgt + DEG_FULL + $urandom_range(0, 40) - 20) % DEG_FULL;
      endcase
      add_fix(h, stamp_us, ($urandom_range(0, 29) == 0));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset configuration: wrap edges, heading reduction, tolerance, cut limit
    add_fix(0, 32'd0, 1'b1);
    add_fix(359, 32'd1000, 1'b0);
    add_fix(180, 32'd2000, 1'b0);
    add_fix(181, 32'd3000, 1'b0);
    add_fix(360, 32'd4000, 1'b0);
    add_fix(511, 32'd5000, 1'b0);
    add_fix(5, 32'd6000, 1'b0);
    add_fix(6, 32'd7000, 1'b0);
    add_fix(35, 32'd8000, 1'b0);
    add_fix(36, 32'd9000, 1'b0);
    add_fix(10, 32'hFFFF_FFFF, 1'b0);
    add_fix(10, 32'd0, 1'b0);
    wait_idle();

    // full gains in turn mode, zero elapsed time with and without error change
    load_setup(16'd359, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd180);
    add_fix(179, 32'd0, 1'b1);
    add_fix(178, 32'd0, 1'b0);
    add_fix(178, 32'd0, 1'b0);
    add_fix(359, 32'd100, 1'b0);
    add_fix(0, 32'd200, 1'b0);
    wait_idle();

    // target above a full circle, zero gains: turn power floor
    load_setup(16'd511, 16'd1, 16'd0, 16'd0, 16'd0, 16'd255);
    add_fix(151, 32'd1000, 1'b1);
    add_fix(300, 32'd2000, 1'b0);
    wait_idle();

    // fractional power rounds to a one step cut, zero tolerance
    load_setup(16'd100, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0);
    add_fix(101, 32'd10, 1'b1);
    add_fix(100, 32'd20, 1'b0);
    add_fix(99, 32'd30, 1'b0);
    wait_idle();

    load_setup(16'd0, 16'd0, 16'd0, 16'd256, 16'd256, 16'd5);
    add_fix(90, 32'd0, 1'b1);
    add_fix(90, 32'd2000000, 1'b0);
    wait_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      load_random_setup();
      queue_random_run(PHASE_FIXES);
      wait_idle();
    end

    repeat (300) @(posedge clk_i);
    fail_cnt += drive_due.size();
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
